// File: sv/bpq_pkg.sv
// Package for the balanced priority run queue insert block.
// Holds the stored entry type, operation, policy, status and register codes.
// Depends on nothing; used by balanced_priority_run_queue_insert_top.
package bpq_pkg;

   typedef struct packed {
      logic [15:0] pid;
      logic [7:0]  prio;
      logic [15:0] time_ms;
   } entry_type;

   localparam int EntryWidth = $bits(entry_type);
   localparam int NumBands   = 3;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_READ   = 1'b1;

   localparam logic [1:0] POL_NORMAL = 2'd0;
   localparam logic [1:0] POL_FIFO   = 2'd1;
   localparam logic [1:0] POL_RR     = 2'd2;
   localparam logic [1:0] POL_OTHER  = 2'd3;

   localparam logic [1:0] BAND_ZERO = 2'd0;
   localparam logic [1:0] BAND_ONE  = 2'd1;
   localparam logic [1:0] BAND_TWO  = 2'd2;
   localparam logic [1:0] BAND_NONE = 2'd3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   localparam logic [2:0] CSR_BAND_ONE_START = 3'd0;
   localparam logic [2:0] CSR_BAND_TWO_START = 3'd1;
   localparam logic [2:0] CSR_NORMAL_LIMIT   = 3'd2;
   localparam logic [2:0] CSR_FIFO_LIMIT     = 3'd3;
   localparam logic [2:0] CSR_RR_LIMIT       = 3'd4;

   localparam logic [7:0]  RESET_BAND_ONE_START = 8'd100;
   localparam logic [7:0]  RESET_BAND_TWO_START = 8'd130;
   localparam logic [5:0]  RESET_NORMAL_LIMIT   = 6'd3;
   localparam logic [5:0]  RESET_FIFO_LIMIT     = 6'd1;
   localparam logic [5:0]  RESET_RR_LIMIT       = 6'd1;
   localparam logic [15:0] RESET_TASK_ID        = 16'd1000;
   localparam logic [5:0]  TALLY_MAX            = 6'd63;

endpackage

// File: sv/bpq_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Width and depth are parameters; no dependencies.
module bpq_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 512,
   localparam int AddrWidth = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AddrWidth-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [AddrWidth-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/balanced_priority_run_queue_insert_top.sv
// Top level of the balanced priority run queue insert block.
// Depends on bpq_pkg for types and codes and on bpq_ram for the entry store.
//
// Usage: drive the req_ fields and raise start; the transaction is taken at a
// clock edge where start is high and busy is low. An insert places a task in
// one of three priority bands of a CPU chosen from per-policy tallies and
// keeps each queue sorted by static priority; a read returns one stored entry.
// Each transaction yields exactly one result, shown on the rsp_ ports for one
// cycle while rsp_valid is high. The receiver cannot stall; busy drops in the
// cycle the result appears, so the next start may be taken in that cycle.
// An insert scans the tally of every CPU (no scan for the other policy), then
// places the task, then walks the queue from its tail through the entry RAM,
// shifting each entry of larger priority up one slot, and then writes the new
// entry, after which the result appears. A full queue ends the insert at
// placement. A read checks the slot and then waits on the registered RAM read;
// an empty slot ends it at the check. Registers are to be written through
// the csr_ port only while the block is idle; the block does not enforce this.
// Reset is synchronous: counts and tallies clear, the pid counter returns to
// 1000 and registers take their defaults; the entry RAM needs no clearing.
module balanced_priority_run_queue_insert_top #(
   parameter int NUM_CPUS    = 4,
   parameter int QUEUE_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_op,
   input  logic [1:0]  req_policy,
   input  logic [7:0]  req_static_priority,
   input  logic [15:0] req_remaining_time,
   input  logic [1:0]  req_cpu_select,
   input  logic [1:0]  req_band_select,
   input  logic [4:0]  req_slot_select,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [1:0]  rsp_cpu,
   output logic [1:0]  rsp_band,
   output logic [4:0]  rsp_position,
   output logic [15:0] rsp_task_id,
   output logic [7:0]  rsp_entry_priority,
   output logic [15:0] rsp_entry_time,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam int NumQueues = NUM_CPUS * bpq_pkg::NumBands;
   localparam int QW        = $clog2(NumQueues);
   localparam int SW        = $clog2(QUEUE_DEPTH);
   localparam int FW        = $clog2(QUEUE_DEPTH + 1);
   localparam int CW        = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
   localparam int AW        = QW + SW;
   localparam int RamDepth  = NumQueues * (1 << SW);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_PLACE  = 3'd2;
   localparam logic [2:0] ST_WALK   = 3'd3;
   localparam logic [2:0] ST_WRITE  = 3'd4;
   localparam logic [2:0] ST_RDCHK  = 3'd5;
   localparam logic [2:0] ST_RDWAIT = 3'd6;

   logic [2:0]  state_ff, state_in;
   logic [1:0]  pol_ff, pol_in;
   logic [7:0]  prio_ff, prio_in;
   logic [15:0] time_ff, time_in;
   logic [1:0]  csel_ff, csel_in;
   logic [4:0]  ssel_ff, ssel_in;
   logic [1:0]  band_ff, band_in;
   logic [CW-1:0] cpu_ff, cpu_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic [5:0]  best_ff, best_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic [15:0] pid_ff;

   logic [7:0]  band_one_ff;
   logic [7:0]  band_two_ff;
   logic [5:0]  normal_limit_ff;
   logic [5:0]  fifo_limit_ff;
   logic [5:0]  rr_limit_ff;

   logic [5:0]    tally_ff [NUM_CPUS][bpq_pkg::NumBands];
   logic [FW-1:0] fill_ff  [NUM_CPUS][bpq_pkg::NumBands];

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [1:0]  rsp_cpu_ff, rsp_cpu_in;
   logic [1:0]  rsp_band_ff, rsp_band_in;
   logic [4:0]  rsp_position_ff, rsp_position_in;
   logic [15:0] rsp_task_id_ff, rsp_task_id_in;
   logic [7:0]  rsp_prio_ff, rsp_prio_in;
   logic [15:0] rsp_time_ff, rsp_time_in;

   logic tally_inc;
   logic fill_inc;
   logic pid_inc;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [bpq_pkg::EntryWidth-1:0] ram_wdata;
   logic          ram_re;
   logic [AW-1:0] ram_raddr;
   logic [bpq_pkg::EntryWidth-1:0] ram_rdata;
   bpq_pkg::entry_type rd_entry;
   bpq_pkg::entry_type new_entry;

   logic          accept;
   logic [1:0]    req_band;
   logic [CW+1:0] req_cpu_ext;
   logic [CW+1:0] cpu_ext;
   logic [SW+4:0] ssel_ext;
   logic [SW+4:0] pos_ext;
   logic [QW-1:0] qidx;
   logic          cpu_ok;
   logic          band_ok;
   logic [FW-1:0] fill_cur;
   logic [FW-1:0] fill_m1;
   logic          slot_ok;
   logic [5:0]    scan_tally;
   logic [5:0]    limit_cur;

   bpq_ram #(
      .WIDTH(bpq_pkg::EntryWidth),
      .DEPTH(RamDepth)
   ) u_entry_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign accept      = start && (state_ff == ST_IDLE);
   assign busy        = (state_ff != ST_IDLE);
   assign rd_entry    = ram_rdata;
   assign new_entry   = '{pid: pid_ff, prio: prio_ff, time_ms: time_ff};
   assign req_cpu_ext = {{CW{1'b0}}, req_cpu_select};
   assign cpu_ext     = {2'b00, cpu_ff};
   assign ssel_ext    = {{SW{1'b0}}, ssel_ff};
   assign pos_ext     = {5'b00000, slot_ff};
   assign qidx        = QW'(cpu_ff) * QW'(bpq_pkg::NumBands) + QW'(band_ff);
   assign cpu_ok      = (32'(csel_ff) < NUM_CPUS);
   assign band_ok     = (band_ff != bpq_pkg::BAND_NONE);
   assign fill_cur    = (cpu_ok || (state_ff == ST_PLACE)) && band_ok ?
                        fill_ff[cpu_ff][band_ff] : '0;
   assign fill_m1     = fill_cur - FW'(1);
   assign slot_ok     = ({{FW{1'b0}}, ssel_ff} < {5'b00000, fill_cur});
   assign scan_tally  = tally_ff[scan_ff][pol_ff];

   always_comb begin
      if (req_static_priority < band_one_ff) begin
         req_band = bpq_pkg::BAND_ZERO;
      end else if (req_static_priority < band_two_ff) begin
         req_band = bpq_pkg::BAND_ONE;
      end else begin
         req_band = bpq_pkg::BAND_TWO;
      end
   end

   always_comb begin
      unique case (pol_ff)
         bpq_pkg::POL_NORMAL: limit_cur = normal_limit_ff;
         bpq_pkg::POL_FIFO:   limit_cur = fifo_limit_ff;
         bpq_pkg::POL_RR:     limit_cur = rr_limit_ff;
         default:             limit_cur = '0;
      endcase
   end

   always_comb begin
      state_in        = state_ff;
      pol_in          = pol_ff;
      prio_in         = prio_ff;
      time_in         = time_ff;
      csel_in         = csel_ff;
      ssel_in         = ssel_ff;
      band_in         = band_ff;
      cpu_in          = cpu_ff;
      scan_in         = scan_ff;
      best_in         = best_ff;
      slot_in         = slot_ff;
      rsp_valid_in    = 1'b0;
      rsp_status_in   = rsp_status_ff;
      rsp_cpu_in      = rsp_cpu_ff;
      rsp_band_in     = rsp_band_ff;
      rsp_position_in = rsp_position_ff;
      rsp_task_id_in  = rsp_task_id_ff;
      rsp_prio_in     = rsp_prio_ff;
      rsp_time_in     = rsp_time_ff;
      tally_inc       = 1'b0;
      fill_inc        = 1'b0;
      pid_inc         = 1'b0;
      ram_we          = 1'b0;
      ram_waddr       = {qidx, slot_ff};
      ram_wdata       = new_entry;
      ram_re          = 1'b0;
      ram_raddr       = {qidx, slot_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pol_in  = req_policy;
               prio_in = req_static_priority;
               time_in = req_remaining_time;
               csel_in = req_cpu_select;
               ssel_in = req_slot_select;
               scan_in = '0;
               if (req_op == bpq_pkg::OP_READ) begin
                  band_in  = req_band_select;
                  cpu_in   = req_cpu_ext[CW-1:0];
                  state_in = ST_RDCHK;
               end else begin
                  band_in = req_band;
                  cpu_in  = '0;
                  if (req_policy == bpq_pkg::POL_OTHER) begin
                     state_in = ST_PLACE;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN: begin
            if ((scan_ff == '0) || ((scan_tally < best_ff) && (scan_tally < limit_cur))) begin
               cpu_in  = scan_ff;
               best_in = scan_tally;
            end
            if (scan_ff == CW'(NUM_CPUS - 1)) begin
               state_in = ST_PLACE;
            end else begin
               scan_in = scan_ff + CW'(1);
            end
         end
         ST_PLACE: begin
            if (fill_cur == FW'(QUEUE_DEPTH)) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = bpq_pkg::STATUS_FULL;
               rsp_cpu_in      = cpu_ext[1:0];
               rsp_band_in     = band_ff;
               rsp_position_in = '0;
               rsp_task_id_in  = pid_ff;
               rsp_prio_in     = prio_ff;
               rsp_time_in     = time_ff;
               state_in        = ST_IDLE;
            end else begin
               tally_inc = (pol_ff != bpq_pkg::POL_OTHER);
               fill_inc  = 1'b1;
               if (fill_cur == '0) begin
                  slot_in  = '0;
                  state_in = ST_WRITE;
               end else begin
                  slot_in   = fill_m1[SW-1:0];
                  ram_re    = 1'b1;
                  ram_raddr = {qidx, fill_m1[SW-1:0]};
                  state_in  = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (rd_entry.prio > prio_ff) begin
               ram_we    = 1'b1;
               ram_waddr = {qidx, slot_ff + SW'(1)};
               ram_wdata = rd_entry;
               if (slot_ff == '0) begin
                  state_in = ST_WRITE;
               end else begin
                  slot_in   = slot_ff - SW'(1);
                  ram_re    = 1'b1;
                  ram_raddr = {qidx, slot_ff - SW'(1)};
               end
            end else begin
               slot_in  = slot_ff + SW'(1);
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            ram_we          = 1'b1;
            rsp_valid_in    = 1'b1;
            rsp_status_in   = bpq_pkg::STATUS_OK;
            rsp_cpu_in      = cpu_ext[1:0];
            rsp_band_in     = band_ff;
            rsp_position_in = pos_ext[4:0];
            rsp_task_id_in  = pid_ff;
            rsp_prio_in     = prio_ff;
            rsp_time_in     = time_ff;
            pid_inc         = 1'b1;
            state_in        = ST_IDLE;
         end
         ST_RDCHK: begin
            if (cpu_ok && band_ok && slot_ok) begin
               ram_re    = 1'b1;
               ram_raddr = {qidx, ssel_ext[SW-1:0]};
               state_in  = ST_RDWAIT;
            end else begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = bpq_pkg::STATUS_EMPTY;
               rsp_cpu_in      = csel_ff;
               rsp_band_in     = band_ff;
               rsp_position_in = ssel_ff;
               rsp_task_id_in  = '0;
               rsp_prio_in     = '0;
               rsp_time_in     = '0;
               state_in        = ST_IDLE;
            end
         end
         ST_RDWAIT: begin
            rsp_valid_in    = 1'b1;
            rsp_status_in   = bpq_pkg::STATUS_OK;
            rsp_cpu_in      = csel_ff;
            rsp_band_in     = band_ff;
            rsp_position_in = ssel_ff;
            rsp_task_id_in  = rd_entry.pid;
            rsp_prio_in     = rd_entry.prio;
            rsp_time_in     = rd_entry.time_ms;
            state_in        = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      pol_ff          <= pol_in;
      prio_ff         <= prio_in;
      time_ff         <= time_in;
      csel_ff         <= csel_in;
      ssel_ff         <= ssel_in;
      band_ff         <= band_in;
      cpu_ff          <= cpu_in;
      scan_ff         <= scan_in;
      best_ff         <= best_in;
      slot_ff         <= slot_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_cpu_ff      <= rsp_cpu_in;
      rsp_band_ff     <= rsp_band_in;
      rsp_position_ff <= rsp_position_in;
      rsp_task_id_ff  <= rsp_task_id_in;
      rsp_prio_ff     <= rsp_prio_in;
      rsp_time_ff     <= rsp_time_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         pid_ff          <= bpq_pkg::RESET_TASK_ID;
         band_one_ff     <= bpq_pkg::RESET_BAND_ONE_START;
         band_two_ff     <= bpq_pkg::RESET_BAND_TWO_START;
         normal_limit_ff <= bpq_pkg::RESET_NORMAL_LIMIT;
         fifo_limit_ff   <= bpq_pkg::RESET_FIFO_LIMIT;
         rr_limit_ff     <= bpq_pkg::RESET_RR_LIMIT;
         for (int c = 0; c < NUM_CPUS; c++) begin
            for (int b = 0; b < bpq_pkg::NumBands; b++) begin
               tally_ff[c][b] <= '0;
               fill_ff[c][b]  <= '0;
            end
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (pid_inc) begin
            pid_ff <= pid_ff + 16'd1;
         end
         if (tally_inc && (tally_ff[cpu_ff][pol_ff] != bpq_pkg::TALLY_MAX)) begin
            tally_ff[cpu_ff][pol_ff] <= tally_ff[cpu_ff][pol_ff] + 6'd1;
         end
         if (fill_inc) begin
            fill_ff[cpu_ff][band_ff] <= fill_cur + FW'(1);
         end
         if (csr_wr_en) begin
            unique case (csr_index)
               bpq_pkg::CSR_BAND_ONE_START: band_one_ff     <= csr_wdata;
               bpq_pkg::CSR_BAND_TWO_START: band_two_ff     <= csr_wdata;
               bpq_pkg::CSR_NORMAL_LIMIT:   normal_limit_ff <= csr_wdata[5:0];
               bpq_pkg::CSR_FIFO_LIMIT:     fifo_limit_ff   <= csr_wdata[5:0];
               bpq_pkg::CSR_RR_LIMIT:       rr_limit_ff     <= csr_wdata[5:0];
               default: begin
               end
            endcase
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_cpu            = rsp_cpu_ff;
   assign rsp_band           = rsp_band_ff;
   assign rsp_position       = rsp_position_ff;
   assign rsp_task_id        = rsp_task_id_ff;
   assign rsp_entry_priority = rsp_prio_ff;
   assign rsp_entry_time     = rsp_time_ff;

endmodule

// File: dv/run_queue_checker.sv
// Checker for the balanced priority run queue insert block: it predicts every result
// transaction from the accepted requests and register writes and compares it field by field.
// Depends on bpq_pkg for the entry type and the operation, policy, status and register codes.
`timescale 1ns / 1ps

module run_queue_checker #(
   parameter int NUM_CPUS    = 4,
   parameter int QUEUE_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        req_op,
   input  logic [1:0]  req_policy,
   input  logic [7:0]  req_static_priority,
   input  logic [15:0] req_remaining_time,
   input  logic [1:0]  req_cpu_select,
   input  logic [1:0]  req_band_select,
   input  logic [4:0]  req_slot_select,
   input  logic        rsp_valid,
   input  logic [1:0]  rsp_status,
   input  logic [1:0]  rsp_cpu,
   input  logic [1:0]  rsp_band,
   input  logic [4:0]  rsp_position,
   input  logic [15:0] rsp_task_id,
   input  logic [7:0]  rsp_entry_priority,
   input  logic [15:0] rsp_entry_time,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata,
   output int          fail_count,
   output int          outstanding,
   output int          placed_count,
   output int          full_count,
   output int          hit_count,
   output int          miss_count
);

   typedef struct packed {
      logic [1:0]  status;
      logic [1:0]  cpu;
      logic [1:0]  band;
      logic [4:0]  position;
      logic [15:0] task_id;
      logic [7:0]  prio;
      logic [15:0] time_ms;
   } outcome_type;

   bpq_pkg::entry_type queue_mem [NUM_CPUS][bpq_pkg::NumBands][QUEUE_DEPTH];
   int          fill_cnt [NUM_CPUS][bpq_pkg::NumBands];
   logic [5:0]  tally [NUM_CPUS][3];
   logic [5:0]  limit_of [3];
   logic [7:0]  band_one_lo;
   logic [7:0]  band_two_lo;
   logic [15:0] pid_next;
   outcome_type awaited_outcomes [$];
   outcome_type next_outcome;

   initial begin
      fail_count   = 0;
      outstanding  = 0;
      placed_count = 0;
      full_count   = 0;
      hit_count    = 0;
      miss_count   = 0;
   end

   task automatic clear_state();
      band_one_lo = bpq_pkg::RESET_BAND_ONE_START;
      band_two_lo = bpq_pkg::RESET_BAND_TWO_START;
      limit_of[bpq_pkg::POL_NORMAL] = bpq_pkg::RESET_NORMAL_LIMIT;
      limit_of[bpq_pkg::POL_FIFO]   = bpq_pkg::RESET_FIFO_LIMIT;
      limit_of[bpq_pkg::POL_RR]     = bpq_pkg::RESET_RR_LIMIT;
      pid_next = bpq_pkg::RESET_TASK_ID;
      for (int c = 0; c < NUM_CPUS; c++) begin
         for (int b = 0; b < bpq_pkg::NumBands; b++) begin
            fill_cnt[c][b] = 0;
         end
         for (int p = 0; p < 3; p++) begin
            tally[c][p] = '0;
         end
      end
      awaited_outcomes.delete();
   endtask

   task automatic apply_write(input logic [2:0] idx, input logic [7:0] value);
      case (idx)
         bpq_pkg::CSR_BAND_ONE_START: band_one_lo = value;
         bpq_pkg::CSR_BAND_TWO_START: band_two_lo = value;
         bpq_pkg::CSR_NORMAL_LIMIT:   limit_of[bpq_pkg::POL_NORMAL] = value[5:0];
         bpq_pkg::CSR_FIFO_LIMIT:     limit_of[bpq_pkg::POL_FIFO] = value[5:0];
         bpq_pkg::CSR_RR_LIMIT:       limit_of[bpq_pkg::POL_RR] = value[5:0];
         default: ;
      endcase
   endtask

   task automatic place_task(input logic [1:0] pol, input logic [7:0] prio,
                             input logic [15:0] tm, output outcome_type o);
      int cpu;
      int band;
      int fill;
      int pos;
      if (prio < band_one_lo) begin
         band = bpq_pkg::BAND_ZERO;
      end else if (prio < band_two_lo) begin
         band = bpq_pkg::BAND_ONE;
      end else begin
         band = bpq_pkg::BAND_TWO;
      end
      cpu = 0;
      if (pol != bpq_pkg::POL_OTHER) begin
         for (int i = 0; i < NUM_CPUS; i++) begin
            if (tally[i][pol] < tally[cpu][pol] && tally[i][pol] < limit_of[pol]) begin
               cpu = i;
            end
         end
      end
      fill = fill_cnt[cpu][band];
      o.cpu = 2'(cpu);
      o.band = 2'(band);
      o.task_id = pid_next;
      o.prio = prio;
      o.time_ms = tm;
      if (fill >= QUEUE_DEPTH) begin
         o.status = bpq_pkg::STATUS_FULL;
         o.position = '0;
         full_count++;
      end else begin
         if (pol != bpq_pkg::POL_OTHER && tally[cpu][pol] < bpq_pkg::TALLY_MAX) begin
            tally[cpu][pol] = tally[cpu][pol] + 6'd1;
         end
         pos = 0;
         while (pos < fill && queue_mem[cpu][band][pos].prio <= prio) begin
            pos++;
         end
         for (int k = fill; k > pos; k--) begin
            queue_mem[cpu][band][k] = queue_mem[cpu][band][k - 1];
         end
         queue_mem[cpu][band][pos] = '{pid: pid_next, prio: prio, time_ms: tm};
         fill_cnt[cpu][band] = fill + 1;
         o.status = bpq_pkg::STATUS_OK;
         o.position = 5'(pos);
         pid_next = pid_next + 16'd1;
         placed_count++;
      end
   endtask

   task automatic fetch_entry(input logic [1:0] cs, input logic [1:0] bs,
                              input logic [4:0] ss, output outcome_type o);
      bit hit;
      hit = 1'b0;
      if (cs < NUM_CPUS && bs < bpq_pkg::NumBands) begin
         hit = (ss < fill_cnt[cs][bs]);
      end
      o.cpu = cs;
      o.band = bs;
      o.position = ss;
      if (hit) begin
         o.status = bpq_pkg::STATUS_OK;
         o.task_id = queue_mem[cs][bs][ss].pid;
         o.prio = queue_mem[cs][bs][ss].prio;
         o.time_ms = queue_mem[cs][bs][ss].time_ms;
         hit_count++;
      end else begin
         o.status = bpq_pkg::STATUS_EMPTY;
         o.task_id = '0;
         o.prio = '0;
         o.time_ms = '0;
         miss_count++;
      end
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   task automatic compare_outcome(input outcome_type want);
      check_field("status", want.status, rsp_status);
      check_field("cpu", want.cpu, rsp_cpu);
      check_field("band", want.band, rsp_band);
      check_field("position", want.position, rsp_position);
      check_field("task_id", want.task_id, rsp_task_id);
      check_field("entry_priority", want.prio, rsp_entry_priority);
      check_field("entry_time", want.time_ms, rsp_entry_time);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_state();
      end else begin
         if (rsp_valid) begin
            if (awaited_outcomes.size() == 0) begin
               $display("%0t: result transaction with none expected, expected none, actual %0d",
                        $time, rsp_task_id);
               fail_count++;
            end else begin
               compare_outcome(awaited_outcomes.pop_front());
            end
         end
         if (csr_wr_en) begin
            apply_write(csr_index, csr_wdata);
         end
         if (start && !busy) begin
            if (req_op == bpq_pkg::OP_READ) begin
               fetch_entry(req_cpu_select, req_band_select, req_slot_select, next_outcome);
            end else begin
               place_task(req_policy, req_static_priority, req_remaining_time, next_outcome);
            end
            awaited_outcomes.push_back(next_outcome);
         end
      end
      outstanding <= awaited_outcomes.size();
   end

endmodule

// File: dv/tb_top.sv
// Top of the testbench: clock, reset, directed and random request transactions and
// register settings for balanced_priority_run_queue_insert_top, and the final verdict.
// Depends on bpq_pkg, the block itself and run_queue_checker.
`timescale 1ns / 1ps

module tb_top;

   localparam int NUM_CPUS    = 4;
   localparam int QUEUE_DEPTH = 32;
   localparam int LATENCY     = NUM_CPUS + QUEUE_DEPTH + 2;
   localparam int STALL_LIMIT = 2000;
   localparam int PHASE_ITEMS = 130;
   localparam logic [2:0] CSR_UNUSED = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_op = bpq_pkg::OP_INSERT;
   logic [1:0]  req_policy = bpq_pkg::POL_NORMAL;
   logic [7:0]  req_static_priority = '0;
   logic [15:0] req_remaining_time = '0;
   logic [1:0]  req_cpu_select = '0;
   logic [1:0]  req_band_select = '0;
   logic [4:0]  req_slot_select = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [1:0]  rsp_cpu;
   logic [1:0]  rsp_band;
   logic [4:0]  rsp_position;
   logic [15:0] rsp_task_id;
   logic [7:0]  rsp_entry_priority;
   logic [15:0] rsp_entry_time;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [7:0]  csr_wdata = '0;

   int fail_count;
   int outstanding;
   int placed_count;
   int full_count;
   int hit_count;
   int miss_count;
   int stall_cycles = 0;
   int item_count = 0;
   logic [7:0] hot_prio [6];

   balanced_priority_run_queue_insert_top #(
      .NUM_CPUS(NUM_CPUS),
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_op(req_op),
      .req_policy(req_policy),
      .req_static_priority(req_static_priority),
      .req_remaining_time(req_remaining_time),
      .req_cpu_select(req_cpu_select),
      .req_band_select(req_band_select),
      .req_slot_select(req_slot_select),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_cpu(rsp_cpu),
      .rsp_band(rsp_band),
      .rsp_position(rsp_position),
      .rsp_task_id(rsp_task_id),
      .rsp_entry_priority(rsp_entry_priority),
      .rsp_entry_time(rsp_entry_time),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   run_queue_checker #(
      .NUM_CPUS(NUM_CPUS),
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_op(req_op),
      .req_policy(req_policy),
      .req_static_priority(req_static_priority),
      .req_remaining_time(req_remaining_time),
      .req_cpu_select(req_cpu_select),
      .req_band_select(req_band_select),
      .req_slot_select(req_slot_select),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_cpu(rsp_cpu),
      .rsp_band(rsp_band),
      .rsp_position(rsp_position),
      .rsp_task_id(rsp_task_id),
      .rsp_entry_priority(rsp_entry_priority),
      .rsp_entry_time(rsp_entry_time),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .fail_count(fail_count),
      .outstanding(outstanding),
      .placed_count(placed_count),
      .full_count(full_count),
      .hit_count(hit_count),
      .miss_count(miss_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_wr_en) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Timeout after %0d cycles without a transaction", stall_cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic issue(input logic op, input logic [1:0] pol, input logic [7:0] prio,
                        input logic [15:0] tm, input logic [1:0] cs, input logic [1:0] bs,
                        input logic [4:0] ss);
      int gap;
      req_op <= op;
      req_policy <= pol;
      req_static_priority <= prio;
      req_remaining_time <= tm;
      req_cpu_select <= cs;
      req_band_select <= bs;
      req_slot_select <= ss;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      item_count++;
      if ((item_count < 350 || item_count >= 500) && $urandom_range(0, 99) < 24) begin
         gap = $urandom_range(1, 12);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
      csr_index <= idx;
      csr_wdata <= value;
      csr_wr_en <= 1'b1;
      @(posedge clock);
   endtask

   task automatic set_hot(input logic [7:0] b1, input logic [7:0] b2);
      hot_prio[0] = b1;
      hot_prio[1] = (b1 == 0) ? b1 : b1 - 8'd1;
      hot_prio[2] = b2;
      hot_prio[3] = (b2 == 0) ? b2 : b2 - 8'd1;
      hot_prio[4] = 8'($urandom_range(0, 139));
      hot_prio[5] = 8'($urandom_range(0, 139));
   endtask

   task automatic program_regs(input logic [7:0] b1, input logic [7:0] b2,
                               input logic [7:0] nl, input logic [7:0] fl,
                               input logic [7:0] rl);
      settle();
      write_reg(bpq_pkg::CSR_BAND_ONE_START, b1);
      write_reg(bpq_pkg::CSR_BAND_TWO_START, b2);
      write_reg(bpq_pkg::CSR_NORMAL_LIMIT, nl);
      write_reg(bpq_pkg::CSR_FIFO_LIMIT, fl);
      write_reg(bpq_pkg::CSR_RR_LIMIT, rl);
      csr_wr_en <= 1'b0;
      set_hot(b1, b2);
   endtask

   task automatic run_random(input int count, input bit normal_heavy);
      logic       op;
      logic [1:0] pol;
      logic [7:0] prio;
      logic [4:0] ss;
      for (int n = 0; n < count; n++) begin
         if (n % 97 == 96) begin
            settle();
         end
         op = ($urandom_range(0, 99) < 40) ? bpq_pkg::OP_READ : bpq_pkg::OP_INSERT;
         if (normal_heavy && $urandom_range(0, 99) < 80) begin
            pol = bpq_pkg::POL_NORMAL;
         end else begin
            pol = 2'($urandom_range(0, 3));
         end
         if ($urandom_range(0, 1) == 1) begin
            prio = 8'($urandom_range(0, 139));
         end else begin
            prio = hot_prio[$urandom_range(0, 5)];
         end
         ss = ($urandom_range(0, 1) == 1) ? 5'($urandom_range(0, 7)) : 5'($urandom);
         issue(op, pol, prio, 16'($urandom), 2'($urandom), 2'($urandom), ss);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reads of empty queues, band extremes, all policies and a run of equal priorities.
      issue(bpq_pkg::OP_READ, bpq_pkg::POL_NORMAL, 8'd0, 16'd0, 2'd0, bpq_pkg::BAND_ZERO, 5'd0);
      issue(bpq_pkg::OP_READ, bpq_pkg::POL_OTHER, 8'd139, 16'hFFFF, 2'd3, bpq_pkg::BAND_NONE,
            5'd31);
      issue(bpq_pkg::OP_INSERT, bpq_pkg::POL_NORMAL, 8'd139, 16'hFFFF, 2'd3, bpq_pkg::BAND_NONE,
            5'd31);
      issue(bpq_pkg::OP_INSERT, bpq_pkg::POL_NORMAL, 8'd0, 16'd0, 2'd0, bpq_pkg::BAND_ZERO,
            5'd0);
      issue(bpq_pkg::OP_INSERT, bpq_pkg::POL_FIFO, 8'd99, 16'd1234, 2'd1, bpq_pkg::BAND_ONE,
            5'd1);
      issue(bpq_pkg::OP_INSERT, bpq_pkg::POL_RR, 8'd100, 16'd4321, 2'd2, bpq_pkg::BAND_TWO,
            5'd2);
      issue(bpq_pkg::OP_INSERT, bpq_pkg::POL_OTHER, 8'd129, 16'd777, 2'd0, bpq_pkg::BAND_ZERO,
            5'd3);
      issue(bpq_pkg::OP_INSERT, bpq_pkg::POL_OTHER, 8'd130, 16'd888, 2'd0, bpq_pkg::BAND_ZERO,
            5'd4);
      for (int k = 0; k < 3; k++) begin
         issue(bpq_pkg::OP_INSERT, bpq_pkg::POL_OTHER, 8'd50, 16'(100 + k), 2'd0,
               bpq_pkg::BAND_ZERO, 5'd0);
      end
      issue(bpq_pkg::OP_INSERT, bpq_pkg::POL_OTHER, 8'd40, 16'd200, 2'd0, bpq_pkg::BAND_ZERO,
            5'd0);
      issue(bpq_pkg::OP_INSERT, bpq_pkg::POL_FIFO, 8'd50, 16'd300, 2'd0, bpq_pkg::BAND_ZERO,
            5'd0);
      for (int s = 0; s < 6; s++) begin
         issue(bpq_pkg::OP_READ, bpq_pkg::POL_NORMAL, 8'd0, 16'd0, 2'd0, bpq_pkg::BAND_ZERO,
               5'(s));
      end
      issue(bpq_pkg::OP_READ, bpq_pkg::POL_NORMAL, 8'd0, 16'd0, 2'd0, bpq_pkg::BAND_TWO, 5'd0);
      issue(bpq_pkg::OP_READ, bpq_pkg::POL_NORMAL, 8'd0, 16'd0, 2'd1, bpq_pkg::BAND_ZERO, 5'd0);
      issue(bpq_pkg::OP_READ, bpq_pkg::POL_NORMAL, 8'd0, 16'd0, 2'd0, bpq_pkg::BAND_ONE, 5'd1);

      set_hot(bpq_pkg::RESET_BAND_ONE_START, bpq_pkg::RESET_BAND_TWO_START);
      run_random(PHASE_ITEMS, 1'b0);

      // Zero limits keep every counted placement on CPU 0.
      program_regs(8'd47, 8'd94, 8'd0, 8'd0, 8'd0);
      run_random(150, 1'b1);

      program_regs(8'd0, 8'd0, 8'd63, 8'd63, 8'd63);
      run_random(PHASE_ITEMS, 1'b0);

      program_regs(8'd139, 8'd139, 8'hFF, 8'd5, 8'd2);
      run_random(PHASE_ITEMS, 1'b0);

      program_regs(8'd70, 8'd30, 8'($urandom_range(0, 63)), 8'($urandom_range(0, 63)),
                   8'($urandom_range(0, 63)));
      @(posedge clock);
      write_reg(CSR_UNUSED, 8'($urandom));
      csr_wr_en <= 1'b0;
      run_random(120, 1'b0);

      program_regs(8'($urandom_range(0, 139)), 8'($urandom_range(0, 139)),
                   8'($urandom_range(0, 63)), 8'($urandom_range(0, 63)),
                   8'($urandom_range(0, 63)));
      run_random(120, 1'b0);

      settle();
      repeat (LATENCY) @(posedge clock);
      $display("Run covered %0d transactions: %0d placements, %0d full-queue rejects,",
               item_count, placed_count, full_count);
      $display("%0d stored-entry reads and %0d empty-slot reads over six register settings.",
               hit_count, miss_count);
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// File: files.f
sv/bpq_pkg.sv
sv/bpq_ram.sv
sv/balanced_priority_run_queue_insert_top.sv
dv/run_queue_checker.sv
dv/tb_top.sv
